// ----- design/jac_pkg.sv -----
// shared types and constants of the joystick axis conditioner
package jac_pkg;

	// converter full scale level
	localparam logic [11:0] FullScale = 12'd4095;

	// divider geometry
	localparam int DivBits = 19;
	localparam int DivisorBits = 12;
	localparam int DivCountBits = 5;

	// stepper direction codes
	localparam logic signed [1:0] DirNone = 2'sb00;
	localparam logic signed [1:0] DirUp = 2'sb01;
	localparam logic signed [1:0] DirDown = 2'sb11;

	// register indexes
	localparam logic [2:0] RegCenter = 3'd0;
	localparam logic [2:0] RegInvert = 3'd1;
	localparam logic [2:0] RegDeadzone = 3'd2;
	localparam logic [2:0] RegStepOn = 3'd3;
	localparam logic [2:0] RegStepOff = 3'd4;
	localparam logic [2:0] RegFirstRep = 3'd5;
	localparam logic [2:0] RegRepPeriod = 3'd6;
	localparam logic [2:0] RegNegate = 3'd7;

	// stepper settings
	typedef struct packed {
		logic [6:0]  step_on_pct;
		logic [6:0]  step_off_pct;
		logic [15:0] first_repeat_ms;
		logic [15:0] repeat_period_ms;
		logic        negate_step;
	} jac_step_cfg_t;

	// divider request
	typedef struct packed {
		logic                   start;
		logic [DivBits-1:0]     dividend;
		logic [DivisorBits-1:0] divisor;
	} jac_div_req_t;

	// divider response
	typedef struct packed {
		logic               done;
		logic [DivBits-1:0] quotient;
	} jac_div_rsp_t;

endpackage

// ----- design/jac_if.sv -----
// sample and result channel interfaces
interface jac_sample_if;
	logic        valid;
	logic        ready;
	logic [11:0] sample;
	logic [31:0] now_ms;

	modport source(output valid, output sample, output now_ms, input ready);
	modport sink(input valid, input sample, input now_ms, output ready);
endinterface

interface jac_result_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] percent;
	logic signed [1:0] step;

	modport source(output valid, output percent, output step, input ready);
	modport sink(input valid, input percent, input step, output ready);
endinterface

// ----- design/jac_div.sv -----
// shared restoring divider, one quotient bit per cycle
module jac_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jac_pkg::jac_div_req_t req,
	output jac_pkg::jac_div_rsp_t rsp
);
	import jac_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [DivCountBits-1:0] cnt_q;
	logic [DivisorBits-1:0]  rem_q;
	logic [DivisorBits-1:0]  divisor_q;
	logic [DivBits-1:0]      quo_q;
	logic [DivisorBits:0]    shifted;
	logic                    ge;

	// trial subtract of the shifted partial remainder
	assign shifted = {rem_q, quo_q[DivBits-1]};
	assign ge = shifted >= {1'b0, divisor_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == DivCountBits'(DivBits - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DivisorBits'(shifted - {1'b0, divisor_q}) : shifted[DivisorBits-1:0];
			quo_q <= {quo_q[DivBits-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule

// ----- design/jac_step.sv -----
// auto-repeat stepper with on and off hysteresis
module jac_step (
	input  logic                   clk,
	input  logic                   arst_n,
	input  jac_pkg::jac_step_cfg_t cfg,
	input  logic                   fire,
	input  logic [6:0]             mag,
	input  logic                   neg,
	input  logic [31:0]            now_ms,
	output logic signed [1:0]      step
);
	import jac_pkg::*;

	logic signed [1:0] latched_q;
	logic [31:0]       next_q;
	logic signed [1:0] latched_d;
	logic [31:0]       next_d;
	logic signed [1:0] sg;
	logic signed [1:0] st;
	logic [31:0]       elapsed;

	assign sg = (mag == 7'd0) ? DirNone : (neg ? DirDown : DirUp);
	assign elapsed = now_ms - next_q;

	// next state and step of this tick
	always_comb begin
		latched_d = latched_q;
		next_d = next_q;
		st = DirNone;
		if (latched_q == DirNone) begin
			if (mag >= cfg.step_on_pct) begin
				latched_d = sg;
				next_d = now_ms + {16'd0, cfg.first_repeat_ms};
				st = sg;
			end
		end else if (mag < cfg.step_off_pct || sg != latched_q) begin
			latched_d = DirNone;
		end else if (!elapsed[31]) begin
			next_d = now_ms + {16'd0, cfg.repeat_period_ms};
			st = latched_q;
		end
		step = cfg.negate_step ? -st : st;
	end

	// stepper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= DirNone;
			next_q <= '0;
		end else if (fire) begin
			latched_q <= latched_d;
			next_q <= next_d;
		end
	end
endmodule

// ----- design/joystick_axis_conditioner_stepper.sv -----
// One sample at a time. With both divisions running, a sample passes through the
// idle state, the setup state, the first division (a start request, then the
// quotient bits of the shared restoring divider), the deadzone state, the second
// division and the output state. Only one division runs when the level falls
// inside the deadzone, or when the span is empty and the deadzone is zero. With
// an empty span and a nonzero deadzone no division runs. Ready is high only while
// the sequencer is idle. The finished result waits in an output register. The
// sequencer stays in its output state while that register still holds an earlier
// result that is not taken. The next sample is taken once the new result has been
// loaded there. Writing center_level also presets the smoothed average. The user
// must write registers only while no sample is in progress; the block itself
// does not enforce this.
module joystick_axis_conditioner_stepper (
	input  logic                clk,
	input  logic                arst_n,
	jac_sample_if.sink          sample_ch,
	jac_result_if.source        result_ch,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import jac_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StPct = 3'd1;
	localparam logic [2:0] StDiv1 = 3'd2;
	localparam logic [2:0] StDz = 3'd3;
	localparam logic [2:0] StDiv2 = 3'd4;
	localparam logic [2:0] StOut = 3'd5;

	logic [2:0]        state_q;
	logic [11:0]       center_q;
	logic              invert_q;
	logic [6:0]        deadzone_q;
	jac_step_cfg_t     step_cfg_q;
	logic [11:0]       smooth_q;
	logic [31:0]       now_q;
	logic [6:0]        mag_q;
	logic              neg_q;
	logic              res_valid_q;
	logic signed [7:0] res_pct_q;
	logic signed [1:0] res_step_q;

	logic              accept;
	logic              load_out;
	logic [13:0]       smooth_sum;
	logic [11:0]       lvl;
	logic [11:0]       ctr;
	logic              upper;
	logic [11:0]       diff;
	logic [11:0]       span;
	logic [6:0]        dz;
	logic [6:0]        dz_span;
	logic [6:0]        q_mag;
	logic signed [1:0] step_now;
	jac_div_req_t      div_req;
	jac_div_rsp_t      div_rsp;

	assign accept = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = state_q == StIdle;
	assign load_out = (state_q == StOut) && (!res_valid_q || result_ch.ready);

	// 3/4 moving average
	assign smooth_sum = {2'b00, smooth_q} * 14'd3 + {2'b00, sample_ch.sample};

	// level, center and span of the active side
	assign lvl = invert_q ? FullScale - smooth_q : smooth_q;
	assign ctr = invert_q ? FullScale - center_q : center_q;
	assign upper = lvl >= ctr;
	assign diff = upper ? lvl - ctr : ctr - lvl;
	assign span = upper ? FullScale - ctr : ctr;

	// deadzone limited to 99
	assign dz = (deadzone_q > 7'd99) ? 7'd99 : deadzone_q;
	assign dz_span = 7'd100 - dz;

	// quotient clamped to 100
	assign q_mag = (div_rsp.quotient > DivBits'(100)) ? 7'd100 : div_rsp.quotient[6:0];

	// divider requests
	always_comb begin
		div_req.start = 1'b0;
		div_req.dividend = '0;
		div_req.divisor = '0;
		if (state_q == StPct && span != 12'd0) begin
			div_req.start = 1'b1;
			div_req.dividend = {7'd0, diff} * DivBits'(100) + {8'd0, span[11:1]};
			div_req.divisor = span;
		end else if (state_q == StDz && mag_q >= dz) begin
			div_req.start = 1'b1;
			div_req.dividend = {12'd0, mag_q - dz} * DivBits'(100)
				+ {13'd0, dz_span[6:1]};
			div_req.divisor = {5'd0, dz_span};
		end
	end

	jac_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	jac_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(step_cfg_q),
		.fire(load_out),
		.mag(mag_q),
		.neg(neg_q),
		.now_ms(now_q),
		.step(step_now)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			case (state_q)
				StIdle: if (accept) state_q <= StPct;
				StPct: state_q <= (span != 12'd0) ? StDiv1 : StDz;
				StDiv1: if (div_rsp.done) state_q <= StDz;
				StDz: state_q <= (mag_q >= dz) ? StDiv2 : StOut;
				StDiv2: if (div_rsp.done) state_q <= StOut;
				StOut: if (load_out) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	// percentage datapath
	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: if (accept) now_q <= sample_ch.now_ms;
			StPct: begin
				neg_q <= !upper;
				mag_q <= 7'd0;
			end
			StDiv1: if (div_rsp.done) mag_q <= q_mag;
			StDz: if (mag_q < dz) mag_q <= 7'd0;
			StDiv2: if (div_rsp.done) mag_q <= q_mag;
			default: ;
		endcase
	end

	// registers and smoothed average
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= 12'd2047;
			invert_q <= 1'b0;
			deadzone_q <= 7'd10;
			step_cfg_q.step_on_pct <= 7'd50;
			step_cfg_q.step_off_pct <= 7'd30;
			step_cfg_q.first_repeat_ms <= 16'd300;
			step_cfg_q.repeat_period_ms <= 16'd100;
			step_cfg_q.negate_step <= 1'b0;
			smooth_q <= 12'd2047;
		end else if (cfg_we) begin
			case (cfg_index)
				RegCenter: begin
					center_q <= cfg_data[11:0];
					smooth_q <= cfg_data[11:0];
				end
				RegInvert: invert_q <= cfg_data[0];
				RegDeadzone: deadzone_q <= cfg_data[6:0];
				RegStepOn: step_cfg_q.step_on_pct <= cfg_data[6:0];
				RegStepOff: step_cfg_q.step_off_pct <= cfg_data[6:0];
				RegFirstRep: step_cfg_q.first_repeat_ms <= cfg_data;
				RegRepPeriod: step_cfg_q.repeat_period_ms <= cfg_data;
				RegNegate: step_cfg_q.negate_step <= cfg_data[0];
				default: ;
			endcase
		end else if (accept) begin
			smooth_q <= smooth_sum[13:2];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_pct_q <= neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
			res_step_q <= step_now;
		end
	end

	assign result_ch.valid = res_valid_q;
	assign result_ch.percent = res_pct_q;
	assign result_ch.step = res_step_q;
endmodule

// ----- bench/joystick_axis_conditioner_stepper_test.sv -----
// self-checking bench for the joystick axis conditioner with auto-repeat stepper
`timescale 1ns / 1ps

module joystick_axis_conditioner_stepper_test;
	import jac_pkg::*;

	// one predicted result transfer
	typedef struct {
		logic signed [7:0] percent;
		logic signed [1:0] step;
	} deflection_t;

	// predicts percent and step from the sample stream and compares transfers
	class deflection_scoreboard;
		logic [11:0]  center_level;
		logic         invert_axis;
		logic [6:0]   deadzone_pct;
		logic [6:0]   step_on_pct;
		logic [6:0]   step_off_pct;
		logic [15:0]  first_repeat_ms;
		logic [15:0]  repeat_period_ms;
		logic         negate_step;
		logic [11:0]  smoothed_level;
		int           latched_dir;
		logic [31:0]  next_step_time;
		deflection_t  pending_deflections[$];
		int           fail_count;

		function new();
			center_level = 12'd2047;
			invert_axis = 1'b0;
			deadzone_pct = 7'd10;
			step_on_pct = 7'd50;
			step_off_pct = 7'd30;
			first_repeat_ms = 16'd300;
			repeat_period_ms = 16'd100;
			negate_step = 1'b0;
			smoothed_level = 12'd2047;
			latched_dir = 0;
			next_step_time = 32'd0;
			fail_count = 0;
		endfunction

		// register write as seen by the block
		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				RegCenter: begin
					center_level = data[11:0];
					smoothed_level = data[11:0];
				end
				RegInvert:    invert_axis = data[0];
				RegDeadzone:  deadzone_pct = data[6:0];
				RegStepOn:    step_on_pct = data[6:0];
				RegStepOff:   step_off_pct = data[6:0];
				RegFirstRep:  first_repeat_ms = data;
				RegRepPeriod: repeat_period_ms = data;
				RegNegate:    negate_step = data[0];
				default: ;
			endcase
		endfunction

		// accepted sample: advance the average and the stepper, queue the outcome
		function void note_sample(logic [11:0] sample, logic [31:0] now_ms);
			int fs, lvl, ctr, span, pct, dz, mag, sg, st, on_lvl, off_lvl, raw;
			logic [31:0] lag;
			deflection_t predicted;
			fs = FullScale;
			raw = sample;
			lvl = smoothed_level;
			lvl = (lvl * 3 + raw) / 4;
			smoothed_level = lvl[11:0];
			ctr = center_level;
			if (invert_axis) begin
				lvl = fs - lvl;
				ctr = fs - ctr;
			end
			// each side scaled by its own span, empty span gives zero
			if (lvl >= ctr) begin
				span = fs - ctr;
				pct = (span > 0) ? ((lvl - ctr) * 100 + span / 2) / span : 0;
			end else begin
				span = ctr;
				pct = (span > 0) ? -(((ctr - lvl) * 100 + span / 2) / span) : 0;
			end
			if (pct > 100) pct = 100;
			if (pct < -100) pct = -100;
			// deadzone cut out and stretched back to full range
			dz = deadzone_pct;
			if (dz > 99) dz = 99;
			if (pct > -dz && pct < dz) begin
				pct = 0;
			end else begin
				mag = (pct < 0) ? -pct : pct;
				mag = ((mag - dz) * 100 + (100 - dz) / 2) / (100 - dz);
				pct = (pct < 0) ? -mag : mag;
			end
			// hysteretic auto-repeat with wrap-safe time compare
			mag = (pct < 0) ? -pct : pct;
			sg = (pct > 0) ? 1 : ((pct < 0) ? -1 : 0);
			on_lvl = step_on_pct;
			off_lvl = step_off_pct;
			st = 0;
			if (latched_dir == 0) begin
				if (mag >= on_lvl) begin
					latched_dir = sg;
					next_step_time = now_ms + 32'(first_repeat_ms);
					st = sg;
				end
			end else if (mag < off_lvl || sg != latched_dir) begin
				latched_dir = 0;
			end else begin
				lag = now_ms - next_step_time;
				if (!lag[31]) begin
					next_step_time = now_ms + 32'(repeat_period_ms);
					st = latched_dir;
				end
			end
			if (negate_step) st = -st;
			predicted.percent = pct[7:0];
			predicted.step = st[1:0];
			pending_deflections.push_back(predicted);
		endfunction

		// result transfer against the oldest prediction
		function void check_result(logic signed [7:0] percent, logic signed [1:0] step);
			deflection_t want;
			if (pending_deflections.size() == 0) begin
				$error("result transfer with no sample outstanding: percent %0d step %0d",
					percent, step);
				fail_count++;
				return;
			end
			want = pending_deflections.pop_front();
			if (percent !== want.percent) begin
				$error("percent mismatch: expected %0d, actual %0d", want.percent, percent);
				fail_count++;
			end
			if (step !== want.step) begin
				$error("step mismatch: expected %0d, actual %0d", want.step, step);
				fail_count++;
			end
		endfunction

		function int outstanding();
			return pending_deflections.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	jac_sample_if sample_ch();
	jac_result_if result_ch();

	deflection_scoreboard deflections;
	logic [31:0] clock_ms;
	int          sample_transfers;
	bit          no_idle;
	bit          hold_results_req;

	joystick_axis_conditioner_stepper DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#20ms;
		$display("** joystick_axis_conditioner_stepper: FAILED **");
		$finish;
	end

	function int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 19);
	endfunction

	// offer one sample and wait for its transfer; valid stays high afterwards
	task automatic send_sample(input logic [11:0] s, input logic [31:0] t);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		sample_ch.now_ms <= t;
		do @(posedge clk); while (!sample_ch.ready);
		deflections.note_sample(s, t);
		sample_transfers++;
	endtask

	// stop offering and wait until every predicted result has been transferred
	task automatic await_results();
		sample_ch.valid <= 1'b0;
		while (deflections.outstanding() != 0) @(posedge clk);
	endtask

	// one register write; the enable is lowered by the caller
	task automatic program_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		deflections.write_reg(idx, data);
	endtask

	// random settings for a phase, extremes drawn often, upper bits sometimes dirty
	task automatic program_random_settings();
		int k, width;
		logic [2:0] idx;
		logic [15:0] value;
		for (k = 0; k < 8; k++) begin
			idx = k[2:0];
			if ($urandom_range(0, 3) != 0) begin
				case (idx)
					RegCenter: begin
						width = 12;
						case ($urandom_range(0, 5))
							0: value = 16'd0;
							1: value = 16'd4095;
							default: value = 16'($urandom_range(0, 4095));
						endcase
					end
					RegInvert, RegNegate: begin
						width = 1;
						value = 16'($urandom_range(0, 1));
					end
					RegDeadzone: begin
						width = 7;
						case ($urandom_range(0, 5))
							0: value = 16'd0;
							1: value = 16'd99;
							2: value = 16'($urandom_range(100, 127));
							default: value = 16'($urandom_range(0, 50));
						endcase
					end
					RegStepOn, RegStepOff: begin
						width = 7;
						case ($urandom_range(0, 6))
							0: value = 16'd0;
							1: value = 16'd100;
							2: value = 16'($urandom_range(101, 127));
							default: value = 16'($urandom_range(0, 100));
						endcase
					end
					default: begin
						width = 16;
						case ($urandom_range(0, 7))
							0: value = 16'd0;
							1: value = 16'hFFFF;
							2: value = 16'($urandom_range(0, 65535));
							default: value = 16'($urandom_range(0, 400));
						endcase
					end
				endcase
				if ($urandom_range(0, 3) == 0)
					value = value | (16'($urandom_range(0, 65535)) & ~16'((1 << width) - 1));
				program_reg(idx, value);
			end
		end
		cfg_we <= 1'b0;
	endtask

	// stick held near one level with jitter, time advancing
	task automatic send_held_run();
		int target, n, k, level, dt_max;
		case ($urandom_range(0, 4))
			0: target = 0;
			1: target = 4095;
			2: target = int'(deflections.center_level) + $urandom_range(0, 600) - 300;
			default: target = $urandom_range(0, 4095);
		endcase
		case ($urandom_range(0, 7))
			0: dt_max = 5;
			1: dt_max = 600;
			2: dt_max = 70000;
			default: dt_max = 150;
		endcase
		n = $urandom_range(3, 25);
		for (k = 0; k < n; k++) begin
			level = target + $urandom_range(0, 60) - 30;
			if (level < 0) level = 0;
			if (level > 4095) level = 4095;
			clock_ms = clock_ms + 32'($urandom_range(0, dt_max));
			send_sample(level[11:0], clock_ms);
		end
	endtask

	// result side: random hold-offs, one long stall on request
	initial begin
		int gap;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_results_req) begin
				hold_results_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				gap = draw_gap();
				if (gap > 0) begin
					result_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			deflections.check_result(result_ch.percent, result_ch.step);
		end
	end

	// main stimulus
	initial begin
		int k, phase, phase_end;
		deflections = new();
		clock_ms = 32'd0;
		sample_transfers = 0;
		no_idle = 1'b0;
		hold_results_req = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= RegCenter;
		cfg_data <= 16'd0;
		sample_ch.valid <= 1'b0;
		sample_ch.sample <= 12'd0;
		sample_ch.now_ms <= 32'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: full down, full up across the timer wrap, back to rest
		for (k = 0; k < 6; k++) send_sample(12'd0, 32'(k * 120));
		for (k = 0; k < 6; k++) send_sample(12'd4095, 32'hFFFF_FF00 + 32'(k * 200));
		send_sample(12'd2047, 32'hFFFF_FFFF);

		// center at zero, inverted, oversized deadzone, zero step_on, negated
		await_results();
		program_reg(RegCenter, 16'hF000);
		program_reg(RegInvert, 16'd1);
		program_reg(RegDeadzone, 16'd127);
		program_reg(RegStepOn, 16'd0);
		program_reg(RegStepOff, 16'd127);
		program_reg(RegFirstRep, 16'd0);
		program_reg(RegRepPeriod, 16'd0);
		program_reg(RegNegate, 16'd1);
		cfg_we <= 1'b0;
		send_sample(12'd4095, 32'd0);
		send_sample(12'd0, 32'd1);
		send_sample(12'd2048, 32'd2);
		send_sample(12'd4095, 32'd3);

		// center at full scale: upper span empty, no deadzone, longest delays
		await_results();
		program_reg(RegCenter, 16'h0FFF);
		program_reg(RegInvert, 16'd0);
		program_reg(RegDeadzone, 16'd0);
		program_reg(RegStepOn, 16'd100);
		program_reg(RegStepOff, 16'd0);
		program_reg(RegFirstRep, 16'hFFFF);
		program_reg(RegRepPeriod, 16'hFFFF);
		program_reg(RegNegate, 16'd0);
		cfg_we <= 1'b0;
		send_sample(12'd4095, 32'd0);
		send_sample(12'd0, 32'd100);
		send_sample(12'd0, 32'd65635);
		send_sample(12'd0, 32'd200000);

		// same center mirrored: lower span empty
		await_results();
		program_reg(RegInvert, 16'hFFFF);
		cfg_we <= 1'b0;
		send_sample(12'd0, 32'd300000);
		send_sample(12'd4095, 32'd300001);
		send_sample(12'd2047, 32'd300002);
		send_sample(12'd4095, 32'd400000);

		// random phases
		for (phase = 0; phase < 21; phase++) begin
			await_results();
			program_random_settings();
			no_idle = (phase % 5 == 2);
			if (phase == 3) hold_results_req = 1'b1;
			if (phase % 7 == 4) clock_ms = 32'hFFFF_F000 + 32'($urandom_range(0, 4095));
			phase_end = sample_transfers + 70;
			while (sample_transfers < phase_end) begin
				if ($urandom_range(0, 4) != 0) begin
					send_held_run();
				end else begin
					for (k = $urandom_range(1, 4); k > 0; k--)
						send_sample(12'($urandom_range(0, 4095)), $urandom());
				end
			end
		end

		// drain and settle
		await_results();
		repeat (60) @(posedge clk);
		if (deflections.fail_count == 0 && deflections.outstanding() == 0) begin
			$display("** joystick_axis_conditioner_stepper: PASSED **");
		end else begin
			$display("** joystick_axis_conditioner_stepper: FAILED **");
		end
		$finish;
	end

endmodule
